### src/mswg_pkg.sv
// Package for the multi-stream WELL512 generator.
// Item types, the sequencer state type and the generator constants.
// No dependencies; mswg_seq, the top level and the testbench import it.
package mswg_pkg;

	localparam int WORD_W = 32;
	localparam int SID_W  = 3;
	localparam int PTR_W  = 4;

	// initialization recurrence and tempering constants
	localparam logic [WORD_W-1:0] INIT_MULT   = 32'd1812433253;
	localparam logic [WORD_W-1:0] TEMPER_MASK = 32'hDA442D24;

	// word offsets relative to the stream position (modulo 16)
	localparam logic [PTR_W-1:0] OFF_C      = 4'd13;
	localparam logic [PTR_W-1:0] OFF_E      = 4'd9;
	localparam logic [PTR_W-1:0] OFF_BACK   = 4'd15;
	localparam logic [PTR_W-1:0] FIRST_WORD = 4'd0;
	localparam logic [PTR_W-1:0] NEXT_WORD  = 4'd1;
	localparam logic [PTR_W-1:0] LAST_WORD  = 4'd15;

	// item modes
	localparam logic MODE_SEED = 1'b0;
	localparam logic MODE_DRAW = 1'b1;

	typedef struct packed {
		logic              mode;
		logic [SID_W-1:0]  stream_id;
		logic [WORD_W-1:0] seed_value;
	} req_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] random_word;
		logic [SID_W-1:0]  from_stream;
	} rsp_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POS,
		ST_RD_A,
		ST_RD_C,
		ST_RD_E,
		ST_WR_R,
		ST_SEED_MUL,
		ST_SEED_WR
	} seq_state_t;

endpackage

### src/mswg_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port,
// read data registered. Uses no package items.
module mswg_ram #(
	parameter int ADDR_W = 4,
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds when no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/mswg_seq.sv
// Sequencer and datapath of the multi-stream WELL512 generator.
// Drives the table and position RAMs; depends on mswg_pkg.
module mswg_seq #(
	parameter int NUM_STREAMS = 8,
	parameter int SIDX_W      = 3,
	parameter int TBL_AW      = 7
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	input  mswg_pkg::req_item_t       req,
	output logic                      req_stall,
	output logic                      tbl_we,
	output logic [TBL_AW-1:0]         tbl_waddr,
	output logic [mswg_pkg::WORD_W-1:0] tbl_wdata,
	output logic                      tbl_re,
	output logic [TBL_AW-1:0]         tbl_raddr,
	input  logic [mswg_pkg::WORD_W-1:0] tbl_rdata,
	output logic                      pos_we,
	output logic [SIDX_W-1:0]         pos_waddr,
	output logic [mswg_pkg::PTR_W-1:0] pos_wdata,
	output logic                      pos_re,
	output logic [SIDX_W-1:0]         pos_raddr,
	input  logic [mswg_pkg::PTR_W-1:0] pos_rdata,
	output logic                      res_valid,
	output mswg_pkg::rsp_item_t       res_item,
	input  logic                      res_take
);
	import mswg_pkg::*;

	seq_state_t          state_q, state_nx;
	logic [SIDX_W-1:0]   sidx_q;
	logic [SID_W-1:0]    sid_q;
	logic [PTR_W-1:0]    p_q;
	logic [WORD_W-1:0]   a_q, b_q, c_q, d_q;
	logic [WORD_W-1:0]   w_q, prod_q;
	logic [PTR_W-1:0]    j_q;
	logic [NUM_STREAMS-1:0] pos_valid_q;

	logic                accept;
	logic                in_range;
	logic [SIDX_W-1:0]   req_sidx;
	logic [PTR_W-1:0]    p_sel;
	logic [WORD_W-1:0]   b_nx, c_nx, a_nx, d_nx, r_nx, w_nx, w_mix;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign in_range  = 32'(req.stream_id) < NUM_STREAMS;
	assign req_sidx  = SIDX_W'(req.stream_id);

	// never-seeded streams read position zero
	assign p_sel = pos_valid_q[sidx_q] ? pos_rdata : FIRST_WORD;

	// WELL512 step pieces
	assign b_nx  = a_q ^ tbl_rdata ^ (a_q << 16) ^ (tbl_rdata << 15);
	assign c_nx  = tbl_rdata ^ (tbl_rdata >> 11);
	assign a_nx  = b_q ^ c_nx;
	assign d_nx  = a_nx ^ ((a_nx << 5) & TEMPER_MASK);
	assign r_nx  = tbl_rdata ^ b_q ^ d_q ^ (tbl_rdata << 2) ^ (b_q << 18) ^ (c_q << 28);

	// seeding recurrence
	assign w_mix = w_q ^ (w_q >> 30);
	assign w_nx  = prod_q + {{(WORD_W-PTR_W){1'b0}}, j_q};

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && in_range) begin
					state_nx = (req.mode == MODE_DRAW) ? ST_POS : ST_SEED_MUL;
				end
			end
			ST_POS:      state_nx = ST_RD_A;
			ST_RD_A:     state_nx = ST_RD_C;
			ST_RD_C:     state_nx = ST_RD_E;
			ST_RD_E:     state_nx = ST_WR_R;
			ST_WR_R: begin
				if (res_take) begin
					state_nx = ST_IDLE;
				end
			end
			ST_SEED_MUL: state_nx = ST_SEED_WR;
			ST_SEED_WR: begin
				if (j_q == LAST_WORD) begin
					state_nx = ST_IDLE;
				end else begin
					state_nx = ST_SEED_MUL;
				end
			end
			default:     state_nx = ST_IDLE;
		endcase
	end

	// outputs: memory ports and result
	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = {sidx_q, p_q};
		tbl_wdata = a_nx;
		tbl_re    = 1'b0;
		tbl_raddr = {sidx_q, p_q};
		pos_we    = 1'b0;
		pos_waddr = sidx_q;
		pos_wdata = 4'(p_q + OFF_BACK);
		pos_re    = 1'b0;
		pos_raddr = req_sidx;
		res_valid = 1'b0;
		res_item.random_word = r_nx;
		res_item.from_stream = sid_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && in_range) begin
					if (req.mode == MODE_DRAW) begin
						pos_re = 1'b1;
					end else begin
						tbl_we    = 1'b1;
						tbl_waddr = {req_sidx, FIRST_WORD};
						tbl_wdata = req.seed_value;
						pos_we    = 1'b1;
						pos_waddr = req_sidx;
						pos_wdata = FIRST_WORD;
					end
				end
			end
			ST_POS: begin
				tbl_re    = 1'b1;
				tbl_raddr = {sidx_q, p_sel};
			end
			ST_RD_A: begin
				tbl_re    = 1'b1;
				tbl_raddr = {sidx_q, 4'(p_q + OFF_C)};
			end
			ST_RD_C: begin
				tbl_re    = 1'b1;
				tbl_raddr = {sidx_q, 4'(p_q + OFF_E)};
			end
			ST_RD_E: begin
				tbl_we    = 1'b1;
				tbl_waddr = {sidx_q, p_q};
				tbl_wdata = a_nx;
				tbl_re    = 1'b1;
				tbl_raddr = {sidx_q, 4'(p_q + OFF_BACK)};
			end
			ST_WR_R: begin
				res_valid = 1'b1;
				if (res_take) begin
					tbl_we    = 1'b1;
					tbl_waddr = {sidx_q, 4'(p_q + OFF_BACK)};
					tbl_wdata = r_nx;
					pos_we    = 1'b1;
				end
			end
			ST_SEED_MUL: begin
			end
			ST_SEED_WR: begin
				tbl_we    = 1'b1;
				tbl_waddr = {sidx_q, j_q};
				tbl_wdata = w_nx;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_valid_q <= '0;
		end else begin
			state_q <= state_nx;
			if (accept && in_range && req.mode == MODE_SEED) begin
				pos_valid_q[req_sidx] <= 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sidx_q <= req_sidx;
			sid_q  <= req.stream_id;
			w_q    <= req.seed_value;
			j_q    <= NEXT_WORD;
		end
		case (state_q)
			ST_POS:      p_q <= p_sel;
			ST_RD_A:     a_q <= tbl_rdata;
			ST_RD_C:     b_q <= b_nx;
			ST_RD_E: begin
				c_q <= c_nx;
				d_q <= d_nx;
			end
			ST_SEED_MUL: prod_q <= w_mix * INIT_MULT;
			ST_SEED_WR: begin
				w_q <= w_nx;
				j_q <= 4'(j_q + NEXT_WORD);
			end
			default: begin
			end
		endcase
	end

endmodule

### src/multi_stream_well512_generator_top.sv
// Top level of the multi-stream WELL512 generator.
// Holds the table and position RAMs, the sequencer and the result register;
// depends on mswg_pkg, mswg_ram and mswg_seq.

// NUM_STREAMS independent WELL512 streams share one table RAM (16 words per
// stream) and one position RAM, both with registered reads. A draw item
// puts its word in the result register as it frees the input; its steps
// are one position read, then four table reads and two table writes through
// the single read and single write port, in sequence. A seed item keeps the
// input stalled and gives no result: the seed word is written on acceptance,
// then each of the fifteen remaining words passes the 32x32 multiplier in
// ST_SEED_MUL and then has its index added and is written in ST_SEED_WR.
// One item is worked on at a time; req_stall is high while the sequencer is
// busy. Items for a stream id at or above NUM_STREAMS are taken and dropped.
// The result register lets a finished word wait on rsp_stall while the next
// item is accepted; a draw whose word is ready holds until that register frees.
// Drawing from a stream that was never seeded returns undefined words.
module multi_stream_well512_generator_top #(
	parameter int NUM_STREAMS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  mswg_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output mswg_pkg::rsp_item_t rsp
);
	import mswg_pkg::*;

	localparam int SIDX_W = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
	localparam int TBL_AW = SIDX_W + PTR_W;

	logic                tbl_we, tbl_re;
	logic [TBL_AW-1:0]   tbl_waddr, tbl_raddr;
	logic [WORD_W-1:0]   tbl_wdata, tbl_rdata;
	logic                pos_we, pos_re;
	logic [SIDX_W-1:0]   pos_waddr, pos_raddr;
	logic [PTR_W-1:0]    pos_wdata, pos_rdata;
	logic                res_valid, res_take;
	rsp_item_t           res_item;
	logic                rsp_valid_q;
	rsp_item_t           rsp_q;

	mswg_ram #(
		.ADDR_W(TBL_AW),
		.DATA_W(WORD_W)
	) u_table (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(tbl_waddr),
		.wdata(tbl_wdata),
		.re   (tbl_re),
		.raddr(tbl_raddr),
		.rdata(tbl_rdata)
	);

	mswg_ram #(
		.ADDR_W(SIDX_W),
		.DATA_W(PTR_W)
	) u_position (
		.clk  (clk),
		.we   (pos_we),
		.waddr(pos_waddr),
		.wdata(pos_wdata),
		.re   (pos_re),
		.raddr(pos_raddr),
		.rdata(pos_rdata)
	);

	mswg_seq #(
		.NUM_STREAMS(NUM_STREAMS),
		.SIDX_W     (SIDX_W),
		.TBL_AW     (TBL_AW)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req      (req),
		.req_stall(req_stall),
		.tbl_we   (tbl_we),
		.tbl_waddr(tbl_waddr),
		.tbl_wdata(tbl_wdata),
		.tbl_re   (tbl_re),
		.tbl_raddr(tbl_raddr),
		.tbl_rdata(tbl_rdata),
		.pos_we   (pos_we),
		.pos_waddr(pos_waddr),
		.pos_wdata(pos_wdata),
		.pos_re   (pos_re),
		.pos_raddr(pos_raddr),
		.pos_rdata(pos_rdata),
		.res_valid(res_valid),
		.res_item (res_item),
		.res_take (res_take)
	);

	// result register: free when empty or being taken this cycle
	assign res_take = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			rsp_q <= res_item;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// a pending word holds steady until the result register takes it
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_take |=> res_valid && $stable(res_item))
		else $error("pending result changed before it was taken");

	// no new item is taken while a word waits in the sequencer
	a_busy_on_res: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> req_stall)
		else $error("item accepted while a result was pending");

	// an in-range draw or seed keeps the block busy on the next cycle
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && (32'(req.stream_id) < NUM_STREAMS) |=> req_stall)
		else $error("sequencer idle right after accepting an item");

endmodule

### sim/tb.sv
// Testbench for multi_stream_well512_generator_top: seeds and draws eight WELL512 streams.
// Every result is checked against a predictor of its own. Depends on mswg_pkg and the
// RTL under src.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mswg_pkg::*;

	localparam int N_STREAMS  = 8;
	localparam int N_DIRECTED = 25;
	localparam int N_RANDOM   = 800;
	localparam int LONG_HOLD  = 80;   // receiver hold-off, in cycles
	localparam int DRAIN_WAIT = 40;   // longer than a seed item keeps the input stalled

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	req_item_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_item_t rsp;

	multi_stream_well512_generator_top #(
		.NUM_STREAMS(N_STREAMS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// predictor state: one 16-word table and one position per stream
	logic [WORD_W-1:0] well_tbl [N_STREAMS][16];
	logic [PTR_W-1:0]  well_pos [N_STREAMS];
	bit                stream_seeded [N_STREAMS];

	// words still owed by the block, oldest first
	rsp_item_t pending_words [$];

	int  mismatches;
	int  send_idle_pct;
	int  recv_stall_pct;
	bit  hold_request;     // asks the receiver for one long hold-off
	req_item_t directed_items [N_DIRECTED];

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// generous upper bound for all 825 items
	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	// Table fill for a seed item: word 0 is the seed, each later word comes from
	// the previous one by the 1812433253 recurrence plus its index.
	function automatic void well_fill_table(int s, logic [WORD_W-1:0] seed);
		logic [WORD_W-1:0] w;
		w = seed;
		well_tbl[s][0] = w;
		for (int j = 1; j < 16; j++) begin
			w = INIT_MULT * (w ^ (w >> 30)) + WORD_W'(j);
			well_tbl[s][j] = w;
		end
		well_pos[s] = FIRST_WORD;
	endfunction

	// One WELL512 step on stream s; updates two table words and the position.
	function automatic logic [WORD_W-1:0] well_next_word(int s);
		logic [PTR_W-1:0]  p, pc, pe;
		logic [WORD_W-1:0] a, b, c, d, r;
		p  = well_pos[s];
		pc = p + OFF_C;
		pe = p + OFF_E;
		a  = well_tbl[s][p];
		c  = well_tbl[s][pc];
		b  = a ^ c ^ (a << 16) ^ (c << 15);
		c  = well_tbl[s][pe];
		c  = c ^ (c >> 11);
		a  = b ^ c;
		well_tbl[s][p] = a;
		d  = a ^ ((a << 5) & TEMPER_MASK);
		p  = p + OFF_BACK;
		a  = well_tbl[s][p];
		r  = a ^ b ^ d ^ (a << 2) ^ (b << 18) ^ (c << 28);
		well_tbl[s][p] = r;
		well_pos[s] = p;
		return r;
	endfunction

	// Work out what an accepted item owes: seeds owe nothing, draws one word.
	function automatic void predict_item(req_item_t it);
		rsp_item_t e;
		if (int'(it.stream_id) >= N_STREAMS)
			return;
		if (it.mode == MODE_SEED) begin
			well_fill_table(it.stream_id, it.seed_value);
			stream_seeded[it.stream_id] = 1'b1;
		end else begin
			e.random_word = well_next_word(it.stream_id);
			e.from_stream = it.stream_id;
			pending_words.push_back(e);
		end
	endfunction

	// Offer one item, with an optional random gap first. Returns at the edge
	// where it is taken; signals read right after the edge are pre-edge values.
	task automatic send_item(req_item_t it);
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			req       <= req_item_t'({$urandom, $urandom});
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= it;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		predict_item(it);
	endtask

	// Random stream among the seeded ones; draws must never hit an unseeded table.
	function automatic logic [SID_W-1:0] pick_seeded();
		logic [SID_W-1:0] s;
		do
			s = SID_W'($urandom_range(N_STREAMS - 1));
		while (!stream_seeded[s]);
		return s;
	endfunction

	// Mostly well-formed traffic: long runs of draws on seeded streams, with
	// reseeds scattered in (random seeds and the all-zero / all-one extremes).
	function automatic req_item_t random_item();
		req_item_t it;
		int        roll;
		roll = $urandom_range(99);
		if (roll < 10) begin
			it.mode       = MODE_SEED;
			it.stream_id  = SID_W'($urandom_range(N_STREAMS - 1));
			case ($urandom_range(9))
				0:       it.seed_value = '0;
				1:       it.seed_value = '1;
				default: it.seed_value = $urandom;
			endcase
		end else begin
			it.mode       = MODE_DRAW;
			it.stream_id  = pick_seeded();
			it.seed_value = $urandom;   // ignored on a draw, but toggled anyway
		end
		return it;
	endfunction

	// Receiver: check whatever was taken at this edge, then choose the stall for
	// the next cycle. A hold request starts a solid stall counted down from LONG_HOLD so
	// the result register fills and the block pushes back on its input.
	initial begin : rsp_side
		rsp_item_t e;
		int        hold_left;
		hold_left = 0;
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall) begin
				if (pending_words.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected word %h from stream %0d",
							$realtime, rsp.random_word, rsp.from_stream);
				end else begin
					e = pending_words.pop_front();
					if (rsp.random_word !== e.random_word ||
							rsp.from_stream !== e.from_stream) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: expected word %h stream %0d, got word %h stream %0d",
								$realtime, e.random_word, e.from_stream,
								rsp.random_word, rsp.from_stream);
					end
				end
			end
			if (hold_request && hold_left == 0) begin
				hold_left    = LONG_HOLD;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	initial begin : req_side
		mismatches     = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_request   = 1'b0;
		foreach (well_pos[i]) begin
			well_pos[i]      = '0;
			stream_seeded[i] = 1'b0;
		end
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;

		// Directed part: extremes of seed and stream id, draws on every seeded
		// stream, sixteen draws on stream 0 so its position goes all the way
		// round, then a reseed that must restart the sequence from a clean table.
		directed_items[0]  = '{MODE_SEED, 3'd0, 32'h0000_0000};
		directed_items[1]  = '{MODE_SEED, 3'd7, 32'hFFFF_FFFF};
		directed_items[2]  = '{MODE_SEED, 3'd3, 32'h8000_0000};
		directed_items[3]  = '{MODE_SEED, 3'd5, 32'h0000_0001};
		directed_items[4]  = '{MODE_DRAW, 3'd7, 32'h0000_0000};
		directed_items[5]  = '{MODE_DRAW, 3'd3, 32'hFFFF_FFFF};
		directed_items[6]  = '{MODE_DRAW, 3'd5, 32'h5A5A_5A5A};
		for (int i = 7; i < 23; i++)
			directed_items[i] = '{MODE_DRAW, 3'd0, 32'h0000_0000};
		directed_items[23] = '{MODE_SEED, 3'd0, 32'hA5A5_A5A5};
		directed_items[24] = '{MODE_DRAW, 3'd0, 32'h0000_0000};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_items[i])
			send_item(directed_items[i]);

		// Random part in four idling phases. The first runs flat out and
		// opens with the long receiver hold-off.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_request = 1'b1; end
				1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
				default: begin send_idle_pct = 28; recv_stall_pct = 28; end
			endcase
			for (int n = 0; n < N_RANDOM / 4; n++)
				send_item(random_item());
		end
		req_valid <= 1'b0;

		// drain, then give a late seed time to show any stray word
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (pending_words.size() != 0)
			mismatches++;
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### filelist.f
src/mswg_pkg.sv
src/mswg_ram.sv
src/mswg_seq.sv
src/multi_stream_well512_generator_top.sv
sim/tb.sv
